@@ sv/assert_macros.svh @@
// Assertion helpers used by plsu_back. All of them sample on the rising
// edge of clk; CHK_RUN is off while the synchronous reset rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset.
`define CHK_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CHK_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/plsu_pkg.sv @@
package plsu_pkg;

  // Address space and paging geometry.
  localparam int ADDR_BITS = 16;
  localparam int PAGE_BITS = 12;
  localparam int ADDR_IN_W = 16;
  localparam int DATA_W    = 32;
  localparam int SIZE_W    = 17;
  localparam int LANES     = DATA_W / 8;
  localparam int WORD_AW   = ADDR_BITS - 2;
  localparam int WORDS     = 1 << WORD_AW;
  localparam int PG_W      = ADDR_BITS - PAGE_BITS;
  localparam int PAGE_COUNT = 1 << PG_W;

  // Width that holds addr + region_size without wrapping.
  localparam int SUM_W = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 1;
  localparam logic [SUM_W-1:0] SPACE_END = SUM_W'(1) << ADDR_BITS;

  // Request queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_LOAD8,
    CMD_LOAD16,
    CMD_LOAD32,
    CMD_FETCH32,
    CMD_STORE8,
    CMD_STORE16,
    CMD_STORE32,
    CMD_MAP
  } cmd_t;

  typedef enum logic [2:0] {
    CAUSE_LOAD_MISALIGNED,
    CAUSE_LOAD_FAULT,
    CAUSE_STORE_MISALIGNED,
    CAUSE_STORE_FAULT,
    CAUSE_FETCH_MISALIGNED,
    CAUSE_FETCH_FAULT
  } cause_t;

  typedef enum logic [1:0] {
    SIZE_BYTE,
    SIZE_HALF,
    SIZE_WORD
  } size_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic                   is_read;
    logic                   is_store;
    size_t                  size;
    logic [1:0]             offset;
    logic [WORD_AW-1:0]     word;
    logic [DATA_W-1:0]      wdata;
    logic                   fault;
    cause_t                 cause;
    logic [ADDR_IN_W-1:0]   fault_addr;
  } lsu_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ sv/plsu_ram.sv @@
module plsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/plsu_front.sv @@
module plsu_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [2:0]                           in_cmd,
  input  logic [plsu_pkg::ADDR_IN_W-1:0]       in_addr,
  input  logic [plsu_pkg::DATA_W-1:0]          in_wdata,
  input  logic [plsu_pkg::SIZE_W-1:0]          in_region_size,
  output plsu_pkg::lsu_req_t                   req
);

  import plsu_pkg::*;

  logic [PAGE_COUNT-1:0] page_map_r;
  logic [PAGE_COUNT-1:0] page_map_nxt;
  logic [PAGE_COUNT-1:0] set_mask;

  cmd_t                 cmd;
  logic [ADDR_BITS-1:0] addr;
  logic [PG_W-1:0]      first_pg;
  logic [PG_W-1:0]      last_pg;
  logic [SUM_W-1:0]     end_sum;
  logic [SUM_W-1:0]     end_clip;
  logic [SUM_W-1:0]     last_byte;
  size_t                size;
  logic                 is_access;
  logic                 is_store;
  logic                 is_fetch;
  logic                 misaligned;
  logic                 mapped;
  logic                 fault;
  cause_t               cause;

  assign cmd  = cmd_t'(in_cmd);
  assign addr = ADDR_BITS'(in_addr);

  // Decode access size and kind.
  always_comb begin
    size      = SIZE_BYTE;
    is_access = 1'b1;
    is_store  = 1'b0;
    is_fetch  = 1'b0;
    unique case (cmd) inside
      CMD_LOAD8:                           size = SIZE_BYTE;
      CMD_LOAD16:                          size = SIZE_HALF;
      CMD_LOAD32:                          size = SIZE_WORD;
      CMD_FETCH32: begin
        size     = SIZE_WORD;
        is_fetch = 1'b1;
      end
      CMD_STORE8: begin
        size     = SIZE_BYTE;
        is_store = 1'b1;
      end
      CMD_STORE16: begin
        size     = SIZE_HALF;
        is_store = 1'b1;
      end
      CMD_STORE32: begin
        size     = SIZE_WORD;
        is_store = 1'b1;
      end
      CMD_MAP:                             is_access = 1'b0;
      default:                             is_access = 1'b0;
    endcase
  end

  // Alignment and page checks. An aligned access never crosses a page or the
  // top of the space, so only the page of the first byte matters.
  always_comb begin
    case (size)
      SIZE_HALF: misaligned = addr[0];
      SIZE_WORD: misaligned = (addr[1:0] != 2'b00);
      default:   misaligned = 1'b0;
    endcase
  end

  assign first_pg = addr[ADDR_BITS-1:PAGE_BITS];
  assign mapped   = page_map_r[first_pg];
  assign fault    = is_access && (misaligned || !mapped);

  always_comb begin
    if (is_fetch) begin
      cause = misaligned ? CAUSE_FETCH_MISALIGNED : CAUSE_FETCH_FAULT;
    end else if (is_store) begin
      cause = misaligned ? CAUSE_STORE_MISALIGNED : CAUSE_STORE_FAULT;
    end else begin
      cause = misaligned ? CAUSE_LOAD_MISALIGNED : CAUSE_LOAD_FAULT;
    end
  end

  // Build the request for the back end. Without a fault the cause reads as
  // code zero and the fault address as zero.
  always_comb begin
    req.is_read    = is_access && !is_store && !fault;
    req.is_store   = is_store && !fault;
    req.size       = size;
    req.offset     = addr[1:0];
    req.word       = addr[ADDR_BITS-1:2];
    req.wdata      = in_wdata;
    req.fault      = fault;
    req.cause      = fault ? cause : CAUSE_LOAD_MISALIGNED;
    req.fault_addr = fault ? ADDR_IN_W'(addr) : '0;
  end

  // Page range covered by a map request, clipped at the top of the space.
  assign end_sum   = SUM_W'(addr) + SUM_W'(in_region_size);
  assign end_clip  = (end_sum > SPACE_END) ? SPACE_END : end_sum;
  assign last_byte = end_clip - SUM_W'(1);
  assign last_pg   = last_byte[ADDR_BITS-1:PAGE_BITS];

  always_comb begin
    for (int p = 0; p < PAGE_COUNT; p++) begin
      set_mask[p] = (PG_W'(p) >= first_pg) && (PG_W'(p) <= last_pg);
    end
  end

  always_comb begin
    page_map_nxt = page_map_r;
    if (accept && (cmd == CMD_MAP) && (in_region_size != '0)) begin
      page_map_nxt = page_map_r | set_mask;
    end
  end

  // Page table: all pages unmapped after reset, never unmapped later.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_map_r <= '0;
    end else begin
      page_map_r <= page_map_nxt;
    end
  end

endmodule

@@ sv/plsu_fifo.sv @@
module plsu_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  plsu_pkg::lsu_req_t   push_req,
  input  logic                 pop,
  output plsu_pkg::lsu_req_t   head,
  output plsu_pkg::fifo_stat_t stat
);

  import plsu_pkg::*;

  lsu_req_t        slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

  // Request slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

@@ sv/plsu_back.sv @@
module plsu_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  plsu_pkg::lsu_req_t              head,
  input  plsu_pkg::fifo_stat_t            stat,
  output logic                            pop,
  output logic                            clearing,
  output logic                            out_valid,
  output logic [plsu_pkg::DATA_W-1:0]     out_rdata,
  output logic                            out_fault,
  output logic [2:0]                      out_cause,
  output logic [plsu_pkg::ADDR_IN_W-1:0]  out_fault_addr
);

  import plsu_pkg::*;

  `include "assert_macros.svh"

  logic                 clearing_r;
  logic [WORD_AW-1:0]   clr_cnt_r;
  logic [WORD_AW-1:0]   clr_cnt_nxt;
  logic                 s1_valid_r;
  lsu_req_t             s1_r;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_rdata_r;
  logic                 out_fault_r;
  cause_t               out_cause_r;
  logic [ADDR_IN_W-1:0] out_fault_addr_r;

  logic [LANES-1:0]     size_mask;
  logic [LANES-1:0]     lane_en;
  logic [DATA_W-1:0]    wdata_sh;
  logic [DATA_W-1:0]    word_rd;
  logic [DATA_W-1:0]    word_sh;
  logic [DATA_W-1:0]    rdata_nxt;

  assign pop      = !stat.empty && !clearing_r;
  assign clearing = clearing_r;

  // Byte lanes touched by the request at the head of the queue.
  always_comb begin
    case (head.size)
      SIZE_BYTE: size_mask = LANES'(4'b0001);
      SIZE_HALF: size_mask = LANES'(4'b0011);
      SIZE_WORD: size_mask = LANES'(4'b1111);
      default:   size_mask = '0;
    endcase
  end

  assign lane_en  = size_mask << head.offset;
  assign wdata_sh = head.wdata << {head.offset, 3'b000};

  // One RAM per byte lane; the clearing pass zeroes one word per cycle.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic       we;
    logic [7:0] wbyte;
    assign we    = clearing_r || (pop && head.is_store && lane_en[l]);
    assign wbyte = clearing_r ? 8'h00 : wdata_sh[8*l +: 8];
    plsu_ram #(
      .WIDTH (8),
      .DEPTH (WORDS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (clearing_r ? clr_cnt_r : head.word),
      .wdata (wbyte),
      .raddr (head.word),
      .rdata (word_rd[8*l +: 8])
    );
  end

  assign clr_cnt_nxt = clr_cnt_r + WORD_AW'(1);

  // Read data alignment and zero extension.
  assign word_sh = word_rd >> {s1_r.offset, 3'b000};

  always_comb begin
    case (s1_r.size)
      SIZE_BYTE: rdata_nxt = {24'h0, word_sh[7:0]};
      SIZE_HALF: rdata_nxt = {16'h0, word_sh[15:0]};
      SIZE_WORD: rdata_nxt = word_sh;
      default:   rdata_nxt = '0;
    endcase
    if (!s1_r.is_read) begin
      rdata_nxt = '0;
    end
  end

  // Control: clearing pass after reset and the result pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_nxt;
        if (clr_cnt_r == '1) begin
          clearing_r <= 1'b0;
        end
      end
      s1_valid_r  <= pop;
      out_valid_r <= s1_valid_r;
    end
  end

  // Payload of the pipeline.
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_r <= head;
    end
    out_rdata_r      <= rdata_nxt;
    out_fault_r      <= s1_r.fault;
    out_cause_r      <= s1_r.cause;
    out_fault_addr_r <= s1_r.fault_addr;
  end

  assign out_valid      = out_valid_r;
  assign out_rdata      = out_rdata_r;
  assign out_fault      = out_fault_r;
  assign out_cause      = out_cause_r;
  assign out_fault_addr = out_fault_addr_r;

  `CHK_ALL(a_no_pop_while_clearing, clearing_r |-> !pop, "request popped during clearing pass")
  `CHK_RUN(a_result_follows_read, s1_valid_r |=> out_valid_r, "read stage did not produce a result")
  `CHK_RUN(a_store_not_faulted, (pop && head.is_store) |-> (!head.fault && !head.is_read), "faulted or mixed store issued")
  `CHK_RUN(a_no_read_zero, (s1_valid_r && !s1_r.is_read) |=> (out_rdata_r == '0), "nonzero data without a read")

endmodule

@@ sv/paged_memory_load_store_unit.sv @@
// Paged byte memory with a load, store, fetch and map-region command port.
// After reset the unit zeroes its memory one 32-bit word per cycle, which
// holds busy high while it clears all 2^(ADDR_BITS-2) words (16384 at 16
// address bits). After that it takes one command per cycle: a command is
// taken when start is high and busy is low, and out_valid marks its result
// once it has passed through the request queue, the memory read and the
// result register, in command order.
// The two stages after the request queue are the memory read and the result
// register; the receiver cannot stall and the back end drains the queue every
// cycle, so busy stays low once the clearing pass is over.
module paged_memory_load_store_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_cmd,
  input  logic [plsu_pkg::ADDR_IN_W-1:0]  in_addr,
  input  logic [plsu_pkg::DATA_W-1:0]     in_wdata,
  input  logic [plsu_pkg::SIZE_W-1:0]     in_region_size,
  output logic                            out_valid,
  output logic [plsu_pkg::DATA_W-1:0]     out_rdata,
  output logic                            out_fault,
  output logic [2:0]                      out_cause,
  output logic [plsu_pkg::ADDR_IN_W-1:0]  out_fault_addr
);

  import plsu_pkg::*;

  lsu_req_t   req;
  lsu_req_t   head;
  fifo_stat_t stat;
  logic       accept;
  logic       pop;
  logic       clearing;

  assign busy   = clearing || stat.full;
  assign accept = start && !busy;

  // Classify requests and keep the page table.
  plsu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_cmd         (in_cmd),
    .in_addr        (in_addr),
    .in_wdata       (in_wdata),
    .in_region_size (in_region_size),
    .req            (req)
  );

  // Queue between classification and memory access.
  plsu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_req (req),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  // Memory access and result formatting.
  plsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .stat           (stat),
    .pop            (pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_rdata      (out_rdata),
    .out_fault      (out_fault),
    .out_cause      (out_cause),
    .out_fault_addr (out_fault_addr)
  );

endmodule

@@ bench/tb_paged_memory_load_store_unit.sv @@
module tb_paged_memory_load_store_unit;
  import plsu_pkg::*;

  localparam int SPACE_BYTES = 1 << ADDR_BITS;
  // The limit leaves room for the clearing pass after reset and all the tests.
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [DATA_W-1:0]    rdata;
    logic                 fault;
    cause_t               cause;
    logic [ADDR_IN_W-1:0] fault_addr;
  } lsu_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [2:0]           in_cmd;
  logic [ADDR_IN_W-1:0] in_addr;
  logic [DATA_W-1:0]    in_wdata;
  logic [SIZE_W-1:0]    in_region_size;
  logic                 out_valid;
  logic [DATA_W-1:0]    out_rdata;
  logic                 out_fault;
  logic [2:0]           out_cause;
  logic [ADDR_IN_W-1:0] out_fault_addr;

  // Shadow copy of the memory contents and the page map.
  bit [7:0] byte_image [0:SPACE_BYTES-1];
  bit       page_is_mapped [0:PAGE_COUNT-1];

  lsu_result_t expected_results[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;

  paged_memory_load_store_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_addr        (in_addr),
    .in_wdata       (in_wdata),
    .in_region_size (in_region_size),
    .out_valid      (out_valid),
    .out_rdata      (out_rdata),
    .out_fault      (out_fault),
    .out_cause      (out_cause),
    .out_fault_addr (out_fault_addr)
  );

  always #2 clk = ~clk;

  // Access width in bytes for a load, store or fetch.
  function automatic int access_bytes(cmd_t c);
    case (c)
      CMD_LOAD16, CMD_STORE16:              return 2;
      CMD_LOAD32, CMD_STORE32, CMD_FETCH32: return 4;
      default:                              return 1;
    endcase
  endfunction

  // Applies one request to the shadow memory and returns its result.
  function automatic lsu_result_t predict_request(cmd_t c, logic [15:0] a, logic [31:0] wd,
                                                  logic [16:0] sz);
    lsu_result_t r;
    int n;
    int kind;
    int where;
    int last_byte;
    int p;
    r = '0;
    if (c == CMD_MAP) begin
      // The region end is clipped at the top of the space.
      if (sz != 0) begin
        last_byte = int'(a) + int'(sz) - 1;
        if (last_byte > SPACE_BYTES - 1) last_byte = SPACE_BYTES - 1;
        for (p = int'(a) >> PAGE_BITS; p <= (last_byte >> PAGE_BITS); p++) begin
          page_is_mapped[p] = 1'b1;
        end
      end
      return r;
    end
    n = access_bytes(c);
    kind = 0;
    where = 0;
    // Alignment first, then range, then the page map byte by byte.
    if ((int'(a) & (n - 1)) != 0) begin
      kind = 1;
      where = int'(a);
    end else if (int'(a) > SPACE_BYTES - n) begin
      kind = 2;
      where = int'(a);
    end else begin
      for (int i = 0; i < n && kind == 0; i++) begin
        if (!page_is_mapped[(int'(a) + i) >> PAGE_BITS]) begin
          kind = 2;
          where = int'(a) + i;
        end
      end
    end
    if (kind != 0) begin
      r.fault = 1'b1;
      r.fault_addr = 16'(where);
      case (c)
        CMD_FETCH32:
          r.cause = (kind == 1) ? CAUSE_FETCH_MISALIGNED : CAUSE_FETCH_FAULT;
        CMD_STORE8, CMD_STORE16, CMD_STORE32:
          r.cause = (kind == 1) ? CAUSE_STORE_MISALIGNED : CAUSE_STORE_FAULT;
        default:
          r.cause = (kind == 1) ? CAUSE_LOAD_MISALIGNED : CAUSE_LOAD_FAULT;
      endcase
    end else if (c == CMD_STORE8 || c == CMD_STORE16 || c == CMD_STORE32) begin
      for (int i = 0; i < n; i++) byte_image[int'(a) + i] = wd[8*i +: 8];
    end else begin
      for (int i = 0; i < n; i++) r.rdata[8*i +: 8] = byte_image[int'(a) + i];
    end
    return r;
  endfunction

  // Drives one request and waits until the unit takes it.
  task automatic send_request(cmd_t c, logic [15:0] a, logic [31:0] wd, logic [16:0] sz);
    @(negedge clk);
    start          <= 1'b1;
    in_cmd         <= c;
    in_addr        <= a;
    in_wdata       <= wd;
    in_region_size <= sz;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(predict_request(c, a, wd, sz));
  endtask

  // Leaves the request line low for a random number of cycles.
  task automatic idle_gap(int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s: expected %h, got %h (cycle %0d)", field, want, got, cycle_count);
  endtask

  // Each result is compared with the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    lsu_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result rdata", '0, out_rdata);
      end else begin
        want = expected_results.pop_front();
        if (out_rdata !== want.rdata) flag_mismatch("rdata", want.rdata, out_rdata);
        if (out_fault !== want.fault)
          flag_mismatch("fault", 32'(want.fault), 32'(out_fault));
        if (out_cause !== want.cause)
          flag_mismatch("cause", 32'(want.cause), 32'(out_cause));
        if (out_fault_addr !== want.fault_addr)
          flag_mismatch("fault_addr", 32'(want.fault_addr), 32'(out_fault_addr));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_paged_memory_load_store_unit: done, errors");
      $finish;
    end
  end

  // Edge cases: unmapped pages, empty and clipped regions, lanes and alignment.
  task automatic test_directed_cases();
    send_request(CMD_LOAD8,   16'h0000, 32'h0, 17'h0);
    send_request(CMD_FETCH32, 16'h0004, 32'h0, 17'h0);
    send_request(CMD_STORE32, 16'h0008, 32'hFFFF_FFFF, 17'h0);
    send_request(CMD_MAP,     16'h1000, 32'h0, 17'h0);
    send_request(CMD_LOAD16,  16'h1000, 32'h0, 17'h0);
    send_request(CMD_MAP,     16'h1800, 32'h0, 17'h1);
    send_request(CMD_LOAD32,  16'h1000, 32'h0, 17'h0);
    send_request(CMD_STORE32, 16'h1000, 32'hDEAD_BEEF, 17'h0);
    send_request(CMD_LOAD8,   16'h1003, 32'h0, 17'h0);
    send_request(CMD_LOAD16,  16'h1002, 32'h0, 17'h0);
    send_request(CMD_FETCH32, 16'h1000, 32'h0, 17'h0);
    send_request(CMD_STORE8,  16'h1001, 32'hFFFF_FF5A, 17'h0);
    send_request(CMD_STORE16, 16'h1002, 32'hABCD_9876, 17'h0);
    send_request(CMD_LOAD32,  16'h1000, 32'h0, 17'h0);
    send_request(CMD_LOAD16,  16'h1001, 32'h0, 17'h0);
    send_request(CMD_LOAD32,  16'h1002, 32'h0, 17'h0);
    send_request(CMD_STORE16, 16'h1003, 32'h1234_5678, 17'h0);
    send_request(CMD_STORE32, 16'h1001, 32'h1234_5678, 17'h0);
    send_request(CMD_FETCH32, 16'h1002, 32'h0, 17'h0);
    // A two-byte region across a page boundary maps both pages.
    send_request(CMD_MAP,     16'h2FFF, 32'h0, 17'h2);
    send_request(CMD_LOAD8,   16'h3000, 32'h0, 17'h0);
    // The largest region from the last byte is clipped at the top.
    send_request(CMD_MAP,     16'hFFFF, 32'h0, 17'h1FFFF);
    send_request(CMD_STORE32, 16'hFFFC, 32'hFFFF_FFFF, 17'h0);
    send_request(CMD_LOAD8,   16'hFFFF, 32'h0, 17'h0);
    send_request(CMD_LOAD32,  16'h0000, 32'h0, 17'h0);
  endtask

  // Mostly aligned accesses near page starts, so loads see earlier stores.
  task automatic test_random_traffic(int count, int idle_pct);
    cmd_t        c;
    logic [15:0] a;
    logic [16:0] sz;
    int          n;
    for (int k = 0; k < count; k++) begin
      idle_gap(idle_pct);
      if ($urandom_range(99) < 3) begin
        c = CMD_MAP;
        a = 16'($urandom);
        case ($urandom_range(9))
          0:       sz = '0;
          1, 2:    sz = 17'($urandom_range(17'h1FFFF));
          default: sz = 17'($urandom_range(4096));
        endcase
      end else begin
        c = cmd_t'($urandom_range(6));
        n = access_bytes(c);
        if ($urandom_range(1) == 1) a = {4'($urandom), 6'h00, 6'($urandom)};
        else a = 16'($urandom);
        if ($urandom_range(99) < 75) a = a & ~16'(n - 1);
        sz = 17'($urandom);
      end
      send_request(c, a, $urandom, sz);
    end
  endtask

  // The sender holds off until every outstanding request has completed.
  task automatic test_quiet_pause();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    send_request(CMD_LOAD32, 16'h1000, 32'h0, 17'h0);
  endtask

  // The whole space mapped at once, then traffic with no page faults.
  task automatic test_full_map();
    send_request(CMD_MAP,    16'h0000, 32'h0, 17'h10000);
    send_request(CMD_LOAD32, 16'h0000, 32'h0, 17'h0);
    send_request(CMD_LOAD32, 16'h7FFC, 32'h0, 17'h0);
    test_random_traffic(150, 25);
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_cmd         = CMD_LOAD8;
    in_addr        = '0;
    in_wdata       = '0;
    in_region_size = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_traffic(450, 0);
    test_random_traffic(450, 57);
    test_quiet_pause();
    test_random_traffic(450, 25);
    test_full_map();

    // Let the pipeline drain, then wait on for any stray results.
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_paged_memory_load_store_unit: done, clean");
    end else begin
      $display("tb_paged_memory_load_store_unit: done, errors");
    end
    $finish;
  end

endmodule
